// ===== sv/lsc_pkg.sv =====
// Shared types, constants and character helpers for the lexeme splitter.
package lsc_pkg;

    localparam int LENGTH_BITS = 8;
    localparam int LINE_BITS   = 16;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_VT     = 8'h0B;
    localparam logic [7:0] CHR_FF     = 8'h0C;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_DQUOTE = 8'h22;
    localparam logic [7:0] CHR_SQUOTE = 8'h27;
    localparam logic [7:0] CHR_LPAREN = 8'h28;
    localparam logic [7:0] CHR_RPAREN = 8'h29;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_DOT    = 8'h2E;
    localparam logic [7:0] CHR_SEMI   = 8'h3B;
    localparam logic [7:0] CHR_LBRACK = 8'h5B;
    localparam logic [7:0] CHR_RBRACK = 8'h5D;
    localparam logic [7:0] CHR_UNDER  = 8'h5F;
    localparam logic [7:0] CHR_LBRACE = 8'h7B;
    localparam logic [7:0] CHR_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        KIND_FUN      = 4'd0,
        KIND_RETURN   = 4'd1,
        KIND_IDENT    = 4'd2,
        KIND_STRING   = 4'd3,
        KIND_INTEGER  = 4'd4,
        KIND_DECIMAL  = 4'd5,
        KIND_SEMI     = 4'd6,
        KIND_LPAREN   = 4'd7,
        KIND_RPAREN   = 4'd8,
        KIND_LBRACE   = 4'd9,
        KIND_RBRACE   = 4'd10,
        KIND_LBRACK   = 4'd11,
        KIND_RBRACK   = 4'd12,
        KIND_EOF      = 4'd13,
        KIND_INVALID  = 4'd14
    } t_kind;

    typedef enum logic [2:0] {
        FIRST_NONE   = 3'd0,
        FIRST_LETTER = 3'd1,
        FIRST_DQUOTE = 3'd2,
        FIRST_SQUOTE = 3'd3,
        FIRST_OTHER  = 3'd4
    } t_first;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_DOUBLE = 2'd1,
        QUOTE_SINGLE = 2'd2
    } t_quote;

    typedef struct packed {
        t_kind                  kind;
        logic [LINE_BITS-1:0]   line;
        logic [LENGTH_BITS-1:0] length;
        logic                   last;
    } t_result;

    // Up to two results leave the lexer core for one byte.
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [7:0] kw_fun_char(input logic [1:0] p);
        logic [7:0] c;
        unique case (p)
            2'd0:    c = 8'h66;
            2'd1:    c = 8'h75;
            default: c = 8'h6E;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_return_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h75;
            3'd4:    c = 8'h72;
            default: c = 8'h6E;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/lsc_lexer_core.sv =====
// Lexer state and per-byte classification, producing up to two results a byte.
module lsc_lexer_core
    import lsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_vld,
    input  logic [7:0] i_byte,
    output t_push      o_push
);

    logic [LENGTH_BITS-1:0] r_len,        n_len;
    logic [LINE_BITS-1:0]   r_line,       n_line;
    logic [LINE_BITS-1:0]   r_start_line, n_start_line;
    t_first                 r_first,      n_first;
    logic                   r_word_ok,    n_word_ok;
    logic                   r_digits_ok,  n_digits_ok;
    logic                   r_dec_ok,     n_dec_ok;
    t_quote                 r_quote,      n_quote;
    logic                   r_fun_ok,     n_fun_ok;
    logic                   r_ret_ok,     n_ret_ok;

    t_kind   pend_kind;
    t_kind   delim_kind;
    logic    is_delim;
    logic    is_space;
    logic    do_flush;
    logic    flush_vld;
    logic    sec_vld;
    t_result flush_res;
    t_result sec_res;

    always_comb begin
        priority if (r_fun_ok && r_len == LENGTH_BITS'(3)) begin
            pend_kind = KIND_FUN;
        end else if (r_ret_ok && r_len == LENGTH_BITS'(6)) begin
            pend_kind = KIND_RETURN;
        end else if (r_first == FIRST_LETTER && r_word_ok) begin
            pend_kind = KIND_IDENT;
        end else if (r_len >= LENGTH_BITS'(2) &&
                     ((r_first == FIRST_DQUOTE && r_quote == QUOTE_DOUBLE) ||
                      (r_first == FIRST_SQUOTE && r_quote == QUOTE_SINGLE))) begin
            pend_kind = KIND_STRING;
        end else if (r_digits_ok) begin
            pend_kind = KIND_INTEGER;
        end else if (r_dec_ok) begin
            pend_kind = KIND_DECIMAL;
        end else begin
            pend_kind = KIND_INVALID;
        end
    end

    always_comb begin
        is_delim   = 1'b1;
        delim_kind = KIND_SEMI;
        unique case (i_byte)
            CHR_SEMI:   delim_kind = KIND_SEMI;
            CHR_COMMA:  delim_kind = KIND_DECIMAL;
            CHR_LPAREN: delim_kind = KIND_LPAREN;
            CHR_RPAREN: delim_kind = KIND_RPAREN;
            CHR_LBRACE: delim_kind = KIND_LBRACE;
            CHR_RBRACE: delim_kind = KIND_RBRACE;
            CHR_LBRACK: delim_kind = KIND_LBRACK;
            CHR_RBRACK: delim_kind = KIND_RBRACK;
            default:    is_delim   = 1'b0;
        endcase
        is_space = (i_byte == CHR_SPACE) || (i_byte == CHR_TAB) || (i_byte == CHR_VT) ||
                   (i_byte == CHR_FF) || (i_byte == CHR_CR);
    end

    always_comb begin
        n_len        = r_len;
        n_line       = r_line;
        n_start_line = r_start_line;
        n_first      = r_first;
        n_word_ok    = r_word_ok;
        n_digits_ok  = r_digits_ok;
        n_dec_ok     = r_dec_ok;
        n_quote      = r_quote;
        n_fun_ok     = r_fun_ok;
        n_ret_ok     = r_ret_ok;
        do_flush     = 1'b0;
        sec_vld      = 1'b0;
        sec_res      = '{kind: KIND_EOF, line: r_line, length: '0, last: 1'b1};

        if (i_byte_vld) begin
            priority if (i_byte == CHR_NUL) begin
                do_flush = 1'b1;
                sec_vld  = 1'b1;
            end else if (is_delim) begin
                do_flush = 1'b1;
                sec_vld  = 1'b1;
                sec_res  = '{kind: delim_kind, line: r_line,
                             length: LENGTH_BITS'(1), last: 1'b1};
            end else if (i_byte == CHR_LF) begin
                do_flush = 1'b1;
                if (r_line != LINE_MAX) begin
                    n_line = r_line + LINE_BITS'(1);
                end
            end else if (is_space) begin
                do_flush = 1'b1;
            end else begin
                if (r_len == '0) begin
                    n_start_line = r_line;
                    priority if (is_letter(i_byte)) begin
                        n_first = FIRST_LETTER;
                    end else if (i_byte == CHR_DQUOTE) begin
                        n_first = FIRST_DQUOTE;
                    end else if (i_byte == CHR_SQUOTE) begin
                        n_first = FIRST_SQUOTE;
                    end else begin
                        n_first = FIRST_OTHER;
                    end
                end else begin
                    n_word_ok = r_word_ok && (is_letter(i_byte) || is_digit(i_byte) ||
                                              i_byte == CHR_UNDER);
                end
                n_digits_ok = r_digits_ok && is_digit(i_byte);
                n_dec_ok    = r_dec_ok && (is_digit(i_byte) || i_byte == CHR_DOT ||
                                           i_byte == CHR_COMMA);
                n_fun_ok    = r_fun_ok && (r_len < LENGTH_BITS'(3)) &&
                              (i_byte == kw_fun_char(r_len[1:0]));
                n_ret_ok    = r_ret_ok && (r_len < LENGTH_BITS'(6)) &&
                              (i_byte == kw_return_char(r_len[2:0]));
                priority if (i_byte == CHR_DQUOTE) begin
                    n_quote = QUOTE_DOUBLE;
                end else if (i_byte == CHR_SQUOTE) begin
                    n_quote = QUOTE_SINGLE;
                end else begin
                    n_quote = QUOTE_NONE;
                end
                if (r_len != LEN_MAX) begin
                    n_len = r_len + LENGTH_BITS'(1);
                end
            end

            if (do_flush && r_len != '0) begin
                n_len       = '0;
                n_first     = FIRST_NONE;
                n_word_ok   = 1'b1;
                n_digits_ok = 1'b1;
                n_dec_ok    = 1'b1;
                n_quote     = QUOTE_NONE;
                n_fun_ok    = 1'b1;
                n_ret_ok    = 1'b1;
            end
            // End of text returns the whole lexer to its reset state.
            if (i_byte == CHR_NUL) begin
                n_line       = '0;
                n_start_line = '0;
            end
        end
    end

    assign flush_vld = do_flush && (r_len != '0);
    assign flush_res = '{kind: pend_kind, line: r_start_line, length: r_len, last: !sec_vld};

    always_comb begin
        o_push.slot0 = flush_vld ? flush_res : sec_res;
        o_push.slot1 = sec_res;
        o_push.count = {1'b0, flush_vld} + {1'b0, sec_vld};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_line       <= '0;
            r_start_line <= '0;
            r_first      <= FIRST_NONE;
            r_word_ok    <= 1'b1;
            r_digits_ok  <= 1'b1;
            r_dec_ok     <= 1'b1;
            r_quote      <= QUOTE_NONE;
            r_fun_ok     <= 1'b1;
            r_ret_ok     <= 1'b1;
        end else begin
            r_len        <= n_len;
            r_line       <= n_line;
            r_start_line <= n_start_line;
            r_first      <= n_first;
            r_word_ok    <= n_word_ok;
            r_digits_ok  <= n_digits_ok;
            r_dec_ok     <= n_dec_ok;
            r_quote      <= n_quote;
            r_fun_ok     <= n_fun_ok;
            r_ret_ok     <= n_ret_ok;
        end
    end

endmodule

// ===== sv/lsc_result_fifo.sv =====
// Small result queue that takes up to two items a cycle and gives one.
module lsc_result_fifo
    import lsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_push               i_push,
    input  logic                i_pop,
    output logic                o_vld,
    output t_result             o_head,
    output logic [CNT_BITS-1:0] o_count
);

    t_result               r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]   r_count,  n_count;
    logic                  pop_ok;

    assign pop_ok   = i_pop && (r_count != '0);
    assign n_wr_ptr = r_wr_ptr + PTR_BITS'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + PTR_BITS'(pop_ok);
    assign n_count  = r_count + CNT_BITS'(i_push.count) - CNT_BITS'(pop_ok);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + PTR_BITS'(1)] <= i_push.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_vld   = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== sv/lexeme_splitter_classifier.sv =====
// Streaming lexer top level: input register, lexer core and result queue.
// An accepted byte is registered, lexed combinationally from that register, and
// its results are written into the result queue, whose head drives the outputs.
// Throughput: one byte per cycle; a byte that causes two results gives them out
// one after the other, and input stalls while more than four results wait in the
// eight-item result queue.
// Reset (synchronous, active low) clears line count, lexeme flags and the queue.
// A zero byte also returns the lexer to line 0 after its end-of-file result.
module lexeme_splitter_classifier
    import lsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_text_byte,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [3:0]             o_token_kind,
    output logic [LINE_BITS-1:0]   o_token_line,
    output logic [LENGTH_BITS-1:0] o_lexeme_length,
    output logic                   o_last_of_run
);

    logic                r_byte_vld;
    logic [7:0]          r_byte;
    logic                accept;
    t_push               push;
    t_result             head;
    logic [CNT_BITS-1:0] q_count;

    // The queue must absorb two results for the byte in the register and
    // two for the byte being accepted.
    assign o_stall = (q_count > CNT_BITS'(FIFO_DEPTH - 4));
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_vld <= 1'b0;
        end else begin
            r_byte_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_text_byte;
        end
    end

    lsc_lexer_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (r_byte_vld),
        .i_byte     (r_byte),
        .o_push     (push)
    );

    lsc_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_vld   (o_valid),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_token_kind    = head.kind;
    assign o_token_line    = head.line;
    assign o_lexeme_length = head.length;
    assign o_last_of_run   = head.last;

endmodule

// ===== sv/lsc_checker.sv =====
// Port-level checks for the lexeme splitter and the bind that attaches them.
module lsc_checker
    import lsc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [3:0]             o_token_kind,
    input logic [LINE_BITS-1:0]   o_token_line,
    input logic [LENGTH_BITS-1:0] o_lexeme_length,
    input logic                   o_last_of_run
);

    // A held result item keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) &&
        $stable(o_token_line) && $stable(o_lexeme_length) && $stable(o_last_of_run))
        else $error("result item changed while stalled");

    // After reset the queue is empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item shown right after reset");

    // End of file is always the final item of its byte and has no length.
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == KIND_EOF |-> o_last_of_run && o_lexeme_length == '0)
        else $error("malformed end-of-file item");

    // An item that is not the last of its byte is a flushed lexeme, never empty.
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> o_lexeme_length != '0 &&
        o_token_kind != KIND_EOF)
        else $error("leading item of a pair is not a pending lexeme");

endmodule

bind lexeme_splitter_classifier lsc_checker u_lsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_token_kind    (o_token_kind),
    .o_token_line    (o_token_line),
    .o_lexeme_length (o_lexeme_length),
    .o_last_of_run   (o_last_of_run)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the streaming lexeme splitter and classifier.
`timescale 1ns / 100ps

module tb;
    import lsc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic [7:0]             i_text_byte = 8'h00;
    logic                   i_stall = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [3:0]             o_token_kind;
    logic [LINE_BITS-1:0]   o_token_line;
    logic [LENGTH_BITS-1:0] o_lexeme_length;
    logic                   o_last_of_run;

    lexeme_splitter_classifier u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_text_byte     (i_text_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_token_kind    (o_token_kind),
        .o_token_line    (o_token_line),
        .o_lexeme_length (o_lexeme_length),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Lexer state mirrored by the predictor.
    logic [LENGTH_BITS-1:0] lex_len;
    logic [LINE_BITS-1:0]   cur_line;
    logic [LINE_BITS-1:0]   lex_line;
    t_first                 lex_first;
    logic                   word_ok;
    logic                   digit_ok;
    logic                   dec_ok;
    t_quote                 tail_quote;
    logic                   fun_hit;
    logic                   ret_hit;

    logic [7:0] fun_chars [3] = '{"f", "u", "n"};
    logic [7:0] ret_chars [6] = '{"r", "e", "t", "u", "r", "n"};

    t_result expected_tokens[$];
    t_result byte_tokens[$];

    int  errors = 0;
    int  sent_count = 0;
    bit  tx_idle_on = 1'b0;
    bit  rx_idle_on = 1'b0;
    int  pressure_req = 0;
    int  pressure_done = 0;
    int  hold_left = 0;
    int  burst_left = 0;
    int  quiet_cycles = 0;

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CHR_SPACE || b == CHR_TAB || b == CHR_VT || b == CHR_FF || b == CHR_CR;
    endfunction

    // Kind of a single-character delimiter; KIND_INVALID when the byte is none.
    function automatic t_kind delim_kind(input logic [7:0] b);
        case (b)
            CHR_SEMI:   return KIND_SEMI;
            CHR_COMMA:  return KIND_DECIMAL;
            CHR_LPAREN: return KIND_LPAREN;
            CHR_RPAREN: return KIND_RPAREN;
            CHR_LBRACE: return KIND_LBRACE;
            CHR_RBRACE: return KIND_RBRACE;
            CHR_LBRACK: return KIND_LBRACK;
            CHR_RBRACK: return KIND_RBRACK;
            default:    return KIND_INVALID;
        endcase
    endfunction

    function automatic t_kind lexeme_kind();
        if (fun_hit && lex_len == 3) return KIND_FUN;
        if (ret_hit && lex_len == 6) return KIND_RETURN;
        if (lex_first == FIRST_LETTER && word_ok) return KIND_IDENT;
        if (lex_len >= 2 && ((lex_first == FIRST_DQUOTE && tail_quote == QUOTE_DOUBLE) ||
                             (lex_first == FIRST_SQUOTE && tail_quote == QUOTE_SINGLE)))
            return KIND_STRING;
        if (digit_ok) return KIND_INTEGER;
        if (dec_ok) return KIND_DECIMAL;
        return KIND_INVALID;
    endfunction

    task automatic clear_lexeme();
        lex_len    = '0;
        lex_first  = FIRST_NONE;
        word_ok    = 1'b1;
        digit_ok   = 1'b1;
        dec_ok     = 1'b1;
        tail_quote = QUOTE_NONE;
        fun_hit    = 1'b1;
        ret_hit    = 1'b1;
    endtask

    task automatic lexer_reset();
        clear_lexeme();
        cur_line = '0;
        lex_line = '0;
    endtask

    task automatic flush_lexeme();
        if (lex_len != 0) begin
            byte_tokens.push_back('{kind: lexeme_kind(), line: lex_line,
                                    length: lex_len, last: 1'b0});
            clear_lexeme();
        end
    endtask

    task automatic append_char(input logic [7:0] b);
        int p;
        p = lex_len;
        if (p == 0) begin
            lex_line = cur_line;
            if (is_alpha(b))           lex_first = FIRST_LETTER;
            else if (b == CHR_DQUOTE)  lex_first = FIRST_DQUOTE;
            else if (b == CHR_SQUOTE)  lex_first = FIRST_SQUOTE;
            else                       lex_first = FIRST_OTHER;
        end else begin
            word_ok = word_ok && (is_alpha(b) || is_num(b) || b == CHR_UNDER);
        end
        digit_ok = digit_ok && is_num(b);
        dec_ok   = dec_ok && (is_num(b) || b == CHR_DOT || b == CHR_COMMA);
        fun_hit  = fun_hit && p < 3 && b == fun_chars[p < 3 ? p : 0];
        ret_hit  = ret_hit && p < 6 && b == ret_chars[p < 6 ? p : 0];
        tail_quote = (b == CHR_DQUOTE) ? QUOTE_DOUBLE :
                     (b == CHR_SQUOTE) ? QUOTE_SINGLE : QUOTE_NONE;
        if (lex_len != LEN_MAX) lex_len++;
    endtask

    // Works out the tokens that one accepted byte releases and queues them.
    task automatic lex_byte(input logic [7:0] b);
        t_kind dk;
        dk = delim_kind(b);
        byte_tokens.delete();
        if (b == CHR_NUL) begin
            flush_lexeme();
            byte_tokens.push_back('{kind: KIND_EOF, line: cur_line, length: '0, last: 1'b0});
            lexer_reset();
        end else if (dk != KIND_INVALID) begin
            flush_lexeme();
            byte_tokens.push_back('{kind: dk, line: cur_line, length: 1, last: 1'b0});
        end else if (b == CHR_LF) begin
            flush_lexeme();
            if (cur_line != LINE_MAX) cur_line++;
        end else if (is_blank(b)) begin
            flush_lexeme();
        end else begin
            append_char(b);
        end
        if (byte_tokens.size() > 0) byte_tokens[$].last = 1'b1;
        foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
    endtask

    // Offers one item and waits until it is taken, then predicts its tokens.
    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        lex_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return rand_letter();
        if (r < 9) return rand_digit();
        return CHR_UNDER;
    endfunction

    function automatic logic [7:0] rand_delim();
        case ($urandom_range(0, 7))
            0:       return CHR_SEMI;
            1:       return CHR_COMMA;
            2:       return CHR_LPAREN;
            3:       return CHR_RPAREN;
            4:       return CHR_LBRACE;
            5:       return CHR_RBRACE;
            6:       return CHR_LBRACK;
            default: return CHR_RBRACK;
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 4))
            0:       return CHR_SPACE;
            1:       return CHR_TAB;
            2:       return CHR_VT;
            3:       return CHR_FF;
            default: return CHR_CR;
        endcase
    endfunction

    // Any byte that stays inside a lexeme.
    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (delim_kind(b) != KIND_INVALID || is_blank(b) || b == CHR_LF);
        return b;
    endfunction

    task automatic send_random_lexeme();
        logic [7:0] q;
        case ($urandom_range(0, 19))
            0, 1: send_text("fun");
            2, 3: send_text("return");
            4: begin
                case ($urandom_range(0, 3))
                    0:       send_text("fu");
                    1:       send_text("funn");
                    2:       send_text("retur");
                    default: send_text("returns");
                endcase
            end
            5, 6, 7: begin
                send_byte(rand_letter());
                repeat ($urandom_range(0, 7)) send_byte(rand_word_char());
                if ($urandom_range(0, 7) == 0) send_byte(rand_plain());
            end
            8, 9: begin
                q = $urandom_range(0, 1) ? CHR_DQUOTE : CHR_SQUOTE;
                send_byte(q);
                repeat ($urandom_range(0, 5)) send_byte(rand_plain());
                case ($urandom_range(0, 5))
                    0:       send_byte(q == CHR_DQUOTE ? CHR_SQUOTE : CHR_DQUOTE);
                    1:       ;
                    default: send_byte(q);
                endcase
            end
            10, 11: repeat ($urandom_range(1, 6)) send_byte(rand_digit());
            12: repeat ($urandom_range(1, 6)) send_byte($urandom_range(0, 2) ? rand_digit() : CHR_DOT);
            13: send_byte(rand_delim());
            14: repeat ($urandom_range(1, 3)) send_byte(rand_blank());
            15: repeat ($urandom_range(1, 3)) send_byte(CHR_LF);
            16: send_byte(8'($urandom_range(1, 255)));
            17: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(128, 255)));
            18: send_byte($urandom_range(0, 5) == 0 ? CHR_NUL : CHR_LF);
            default: begin
                // Now and then a lexeme near or past the length limit, so the length can saturate.
                if ($urandom_range(0, 19) == 0)
                    repeat ($urandom_range(250, 270)) send_byte(rand_word_char());
                else
                    repeat ($urandom_range(1, 10)) send_byte(rand_plain());
            end
        endcase
        case ($urandom_range(0, 5))
            0, 1: send_byte(CHR_SPACE);
            2:    send_byte(rand_delim());
            3:    send_byte(CHR_LF);
            4:    send_byte(rand_blank());
            default: ;
        endcase
    endtask

    task automatic test_keywords();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_text("fun return funx retur Fun\n");
    endtask

    task automatic test_delimiters();
        send_text("x;(){}[],y ;");
    endtask

    task automatic test_classes();
        send_text("\"ab\" 'c' \"x' \" 0917 3.14 1.2 _a 9x @ ");
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(CHR_SPACE);
        send_byte(CHR_DQUOTE);
        send_byte(8'hFF);
        send_byte(CHR_DQUOTE);
        send_byte(CHR_LF);
    endtask

    task automatic test_blanks_and_eof();
        send_byte(CHR_SPACE);
        send_byte(CHR_TAB);
        send_byte(CHR_VT);
        send_byte(CHR_FF);
        send_byte(CHR_CR);
        send_byte(CHR_LF);
        send_byte(CHR_LF);
        send_text("ab");
        send_byte(CHR_NUL);
        send_byte(CHR_NUL);
        send_text("z");
        send_byte(CHR_NUL);
    endtask

    task automatic test_long_lexeme();
        repeat (300) send_byte("a");
        send_byte(CHR_SPACE);
        send_text("fun");
        repeat (260) send_byte(rand_digit());
        send_byte(CHR_SEMI);
    endtask

    // Lexemes after runs of newlines keep the line on which they began.
    task automatic test_line_count();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_text("a\n");
        repeat (3) send_byte(CHR_LF);
        send_text("ab\nc");
        send_byte(CHR_NUL);
    endtask

    // The receiver holds off while delimiter-heavy text keeps coming, so the
    // result queue fills and the block has to stall its input.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        pressure_req++;
        repeat (20) send_text("a;");
        send_text("(b)[c]{d}");
    endtask

    task automatic test_random_text(input int n_items, input bit with_idle);
        int stop_at;
        stop_at    = sent_count + n_items;
        tx_idle_on = with_idle;
        rx_idle_on = with_idle;
        while (sent_count < stop_at) send_random_lexeme();
    endtask

    always @(posedge i_clk) begin
        if (pressure_req != pressure_done) begin
            pressure_done = pressure_req;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_stall <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(0, 14);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_tokens
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual kind %0d line %0d len %0d",
                         $time, o_token_kind, o_token_line, o_lexeme_length);
                errors++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", want.kind, o_token_kind);
                check_field("token_line", want.line, o_token_line);
                check_field("lexeme_length", want.length, o_lexeme_length);
                check_field("last_of_run", want.last, o_last_of_run);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        lexer_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_keywords();
        test_delimiters();
        test_classes();
        test_blanks_and_eof();
        test_long_lexeme();
        test_line_count();
        test_backpressure();
        test_random_text(650, 1'b1);
        test_random_text(180, 1'b0);
        i_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
